### src/rsm_pkg.sv
// shared constants, codes and types for the wildcard star regex matcher
package rsm_pkg;

  localparam int PATTERN_MAX = 32;
  localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
  localparam int IDX_W       = $clog2(PATTERN_MAX);
  localparam int NUM_WORDS   = 4;
  localparam int BYTES_WORD  = 8;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_ADDR_W  = 3;
  localparam int CNT_W       = 6;

  localparam logic [CFG_ADDR_W-1:0] REG_PAT0  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_PAT1  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_PAT2  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_PAT3  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_COUNT = 3'd4;

  localparam logic OP_START = 1'b0;
  localparam logic OP_FEED  = 1'b1;

  localparam logic [7:0] STAR_BYTE = 8'h2A;
  localparam logic [7:0] DOT_BYTE  = 8'h2E;

  typedef logic [NUM_WORDS-1:0][BYTES_WORD-1:0][7:0] pattern_t;

  typedef struct packed {
    logic feed;
    logic first;
    logic old_jm1;
    logic old_j;
    logic next_jm2;
  } cell_ctl_t;

endpackage

### src/rsm_in_if.sv
// request channel carrying opcode and text byte
interface rsm_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] text_char;

  modport source (output valid, output opcode, output text_char, input ready);
  modport sink (input valid, input opcode, input text_char, output ready);
endinterface

### src/rsm_out_if.sv
// result channel carrying the match flag
interface rsm_out_if;
  logic valid;
  logic ready;
  logic matched;

  modport source (output valid, output matched, input ready);
  modport sink (input valid, input matched, output ready);
endinterface

### src/rsm_cell.sv
// one match cell: computes the row bit for a single pattern position
module rsm_cell (
  input  rsm_pkg::cell_ctl_t ctl,
  input  logic [7:0]         text_char,
  input  logic [7:0]         pat_byte,
  input  logic [7:0]         prev_byte,
  output logic               hit
);
  import rsm_pkg::*;

  logic cur_fits;
  logic prev_fits;
  logic is_star;

  assign is_star   = (pat_byte == STAR_BYTE);
  assign cur_fits  = (text_char == pat_byte) || (pat_byte == DOT_BYTE);
  assign prev_fits = (text_char == prev_byte) || (prev_byte == DOT_BYTE);

  always_comb begin
    if (!ctl.feed) begin
      hit = is_star && !ctl.first && ctl.next_jm2;
    end else if (!is_star) begin
      hit = cur_fits && ctl.old_jm1;
    end else begin
      // star: zero copies, or one more copy of the byte before it
      hit = !ctl.first && (ctl.next_jm2 || (prev_fits && ctl.old_j));
    end
  end

endmodule

### src/wildcard_star_regex_matcher.sv
// top level: pattern registers, row state and the position sequencer
// An item is first loaded into the payload registers; then the single match cell
// sweeps the len pattern positions one by one in order, where len is pattern_count
// capped at 32, and last the result of the sweep is posted to the output register.
// A start request rebuilds the row for empty text; a feed request advances it by one
// text byte. Each request gives one result that tells whether the text since the last
// start matches the whole pattern. The result sits in an output register, so a new
// request is taken while it waits; the sweep stalls at its end only if the earlier
// result has not been taken yet. Pattern writes belong between texts or while idle.
module wildcard_star_regex_matcher (
  input  logic                            clk,
  input  logic                            rst_n,
  rsm_in_if.sink                          in_ch,
  rsm_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [rsm_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [rsm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import rsm_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  pattern_t               pat_r;
  logic [CNT_W-1:0]       count_r;
  logic                   state_r;
  logic                   state_nxt;
  logic                   feed_r;
  logic [7:0]             char_r;
  logic [LEN_W-1:0]       j_r;
  logic [PATTERN_MAX:0]   row_r;
  logic [PATTERN_MAX:0]   old_sh_r;
  logic                   n1_r;
  logic                   n2_r;
  logic [7:0]             prev_byte_r;
  logic                   out_valid_r;
  logic                   matched_r;

  logic [LEN_W-1:0]       len;
  logic [IDX_W-1:0]       idx;
  logic [7:0]             cur_byte;
  logic                   accept;
  logic                   sweep_done;
  logic                   slot_free;
  logic                   finish;
  logic                   step;
  logic                   hit;
  cell_ctl_t              ctl;

  assign len = (count_r > CNT_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : LEN_W'(count_r);
  assign idx = IDX_W'(j_r - LEN_W'(1));
  assign cur_byte = pat_r[idx[IDX_W-1:3]][idx[2:0]];

  assign accept     = in_ch.valid && in_ch.ready;
  assign sweep_done = (j_r > len);
  assign slot_free  = !out_valid_r || out_ch.ready;
  assign step       = (state_r == ST_RUN) && !sweep_done;
  assign finish     = (state_r == ST_RUN) && sweep_done && slot_free;

  assign in_ch.ready    = (state_r == ST_IDLE);
  assign out_ch.valid   = out_valid_r;
  assign out_ch.matched = matched_r;

  assign ctl.feed     = feed_r;
  assign ctl.first    = (j_r == LEN_W'(1));
  assign ctl.old_jm1  = old_sh_r[0];
  assign ctl.old_j    = old_sh_r[1];
  assign ctl.next_jm2 = n2_r;

  rsm_cell u_cell (
    .ctl       (ctl),
    .text_char (char_r),
    .pat_byte  (cur_byte),
    .prev_byte (prev_byte_r),
    .hit       (hit)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_RUN;
      ST_RUN:  if (finish) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r   <= '0;
      count_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_PAT0, REG_PAT1, REG_PAT2, REG_PAT3: pat_r[cfg_addr[1:0]] <= cfg_wdata;
        REG_COUNT: count_r <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and row state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      row_r       <= (PATTERN_MAX+1)'(1);
      out_valid_r <= 1'b0;
      j_r         <= '0;
    end else begin
      state_r <= state_nxt;
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (accept) begin
        j_r   <= LEN_W'(1);
        row_r <= (PATTERN_MAX+1)'(in_ch.opcode == OP_START);
      end else if (step) begin
        row_r[j_r] <= hit;
        j_r        <= j_r + LEN_W'(1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      feed_r   <= in_ch.opcode;
      char_r   <= in_ch.text_char;
      old_sh_r <= row_r;
      n1_r     <= (in_ch.opcode == OP_START);
      n2_r     <= 1'b0;
    end else if (step) begin
      old_sh_r    <= {1'b0, old_sh_r[PATTERN_MAX:1]};
      prev_byte_r <= cur_byte;
      n2_r        <= n1_r;
      n1_r        <= hit;
    end
    if (finish) matched_r <= n1_r;
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> (state_r == ST_IDLE))
    else $error("request taken while the sweep is busy");

  a_accept_runs: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_RUN) && (j_r == LEN_W'(1)))
    else $error("sweep did not start after a request");

  a_j_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (j_r <= len + LEN_W'(1)))
    else $error("position counter ran past the pattern");

  a_finish_posts: assert property (@(posedge clk) disable iff (!rst_n)
    finish |=> out_valid_r && (state_r == ST_IDLE))
    else $error("finished sweep did not post a result");

  a_feed_clears_bit0: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) && feed_r |-> !row_r[0])
    else $error("empty prefix matched after a text byte");

endmodule
